FILE: src/console_bus_decode_with_sprite_dma_unit_assert.svh
// Assertion macros shared by the console bus decoder RTL.
// The macros expect clk_i and rst_ni in the scope where they are used.
`ifndef CONSOLE_BUS_DECODE_WITH_SPRITE_DMA_UNIT_ASSERT_SVH
`define CONSOLE_BUS_DECODE_WITH_SPRITE_DMA_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cbd_pkg.sv
// Package of the console bus decoder: operation and target codes, address map,
// clock phase constants and the structs passed between the modules.
// Depends on nothing.
package cbd_pkg;

  localparam int RAM_DEPTH_DEF = 2048;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 3;

  localparam logic [15:0] RAM_END       = 16'h1FFF;
  localparam logic [15:0] PPU_BASE      = 16'h2000;
  localparam logic [15:0] PPU_END       = 16'h3FFF;
  localparam logic [15:0] DMA_PAGE_ADDR = 16'h4014;
  localparam logic [15:0] PAD0_ADDR     = 16'h4016;
  localparam logic [15:0] PAD1_ADDR     = 16'h4017;

  localparam logic [2:0] PHASE_READ       = 3'd0;
  localparam logic [2:0] PHASE_AFTER_READ = 3'd1;
  localparam logic [2:0] PHASE_WRITE      = 3'd3;
  localparam logic [2:0] PHASE_LAST       = 3'd5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_CART = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_PPU  = 3'd3,
    TGT_DMA  = 3'd4,
    TGT_PAD  = 3'd5
  } target_e;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        read_only;
    logic        cart_hit;
    logic [7:0]  cart_data;
    logic [7:0]  ppu_data;
    logic [7:0]  pad_a;
    logic [7:0]  pad_b;
    logic        nmi_pending;
  } in_t;

  typedef struct packed {
    logic [1:0][7:0] pad_shift;
    logic [7:0]      page;
    logic [7:0]      offset;
    logic            waiting;
    logic            running;
    logic [2:0]      phase;
  } state_t;

  typedef struct packed {
    logic [7:0]  rd_imm;
    logic        rd_from_ram;
    logic        dma_capture;
    target_e     target;
    logic [2:0]  ppu_register;
    logic        ppu_peek;
    logic [15:0] bus_address;
    logic        cpu_clock_enable;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_active;
    logic        nmi_to_cpu;
  } stage_t;

  typedef struct packed {
    logic [7:0]  read_data;
    target_e     target;
    logic [2:0]  ppu_register;
    logic        ppu_peek;
    logic [15:0] bus_address;
    logic        cpu_clock_enable;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_active;
    logic        nmi_to_cpu;
  } res_t;

endpackage

FILE: src/console_bus_decode_with_sprite_dma_unit.sv
// Channel  Direction  tuser          tdata
// s_axis   in         operation      address, write_data, read_only, cart_hit, cart_data,
//                                    ppu_data, pad_a, pad_b, nmi_pending
// m_axis   out        target         read_data, ppu_register, ppu_peek, bus_address,
//                                    cpu_clock_enable, oam_write, oam_index, oam_data,
//                                    dma_active, nmi_to_cpu
// One transaction is accepted per cycle while the stage register is free and no RAM clear
// runs, and its result passes through the stage register and the result register.
// The work RAM is a single memory with a registered read port, which is why the pipeline has two stages.
// After reset the RAM is cleared one entry a cycle, with s_axis_tready low. A stalled m_axis
// holds the result register, and input is still taken while the stage register is free.
// Top level of the console bus decoder. Depends on cbd_pkg, cbd_ram, cbd_decode and
// the assertion macro header.
`include "console_bus_decode_with_sprite_dma_unit_assert.svh"

module console_bus_decode_with_sprite_dma_unit #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // address[15:0], write_data[23:16], read_only[24], cart_hit[25], cart_data[33:26],
  // ppu_data[41:34], pad_a[49:42], pad_b[57:50], nmi_pending[58], zero[63:59]
  input  logic [cbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [cbd_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data[7:0], ppu_register[10:8], ppu_peek[11], bus_address[27:12],
  // cpu_clock_enable[28], oam_write[29], oam_index[37:30], oam_data[45:38],
  // dma_active[46], nmi_to_cpu[47]
  output logic [cbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // target[2:0]
  output logic [cbd_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  localparam int AW = $clog2(RAM_DEPTH);
  localparam int CW = $clog2(RAM_DEPTH + 1);

  cbd_pkg::in_t    in_fields;
  cbd_pkg::op_e    in_op;
  cbd_pkg::state_t state_q;
  cbd_pkg::state_t state_d;
  cbd_pkg::stage_t stage_d;
  cbd_pkg::stage_t s1_q;
  cbd_pkg::res_t   out_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic [7:0]      dma_byte_q;
  logic [CW-1:0]   clr_cnt_q;
  logic            clr_busy;
  logic            accept;
  logic            s1_load;
  logic            s1_adv;
  logic            dec_we;
  logic            dec_re;
  logic [AW-1:0]   dec_idx;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic [7:0]      rd_final;

  assign in_op = cbd_pkg::op_e'(s_axis_tuser);
  assign in_fields.address     = s_axis_tdata[15:0];
  assign in_fields.write_data  = s_axis_tdata[23:16];
  assign in_fields.read_only   = s_axis_tdata[24];
  assign in_fields.cart_hit    = s_axis_tdata[25];
  assign in_fields.cart_data   = s_axis_tdata[33:26];
  assign in_fields.ppu_data    = s_axis_tdata[41:34];
  assign in_fields.pad_a       = s_axis_tdata[49:42];
  assign in_fields.pad_b       = s_axis_tdata[57:50];
  assign in_fields.nmi_pending = s_axis_tdata[58];

  assign clr_busy      = clr_cnt_q != CW'(RAM_DEPTH);
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s1_load       = !s1_valid_q || s1_adv;
  assign s_axis_tready = !clr_busy && s1_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbd_decode #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_decode (
    .op_i      (in_op),
    .in_i      (in_fields),
    .state_i   (state_q),
    .dma_byte_i(dma_byte_q),
    .state_o   (state_d),
    .stage_o   (stage_d),
    .ram_we_o  (dec_we),
    .ram_re_o  (dec_re),
    .ram_idx_o (dec_idx)
  );

  assign ram_we    = clr_busy || (accept && dec_we);
  assign ram_waddr = clr_busy ? clr_cnt_q[AW-1:0] : dec_idx;
  assign ram_wdata = clr_busy ? 8'd0 : in_fields.write_data;

  cbd_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept && dec_re),
    .raddr_i(dec_idx),
    .rdata_o(ram_rdata)
  );

  assign rd_final = s1_q.rd_from_ram ? ram_rdata : s1_q.rd_imm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pad_shift <= '0;
      state_q.page      <= '0;
      state_q.offset    <= '0;
      state_q.waiting   <= 1'b1;
      state_q.running   <= 1'b0;
      state_q.phase     <= '0;
      dma_byte_q        <= '0;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (s1_load) begin
        s1_valid_q <= accept;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv && s1_valid_q && s1_q.dma_capture) begin
        dma_byte_q <= rd_final;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= stage_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q.read_data        <= rd_final;
      out_q.target           <= s1_q.target;
      out_q.ppu_register     <= s1_q.ppu_register;
      out_q.ppu_peek         <= s1_q.ppu_peek;
      out_q.bus_address      <= s1_q.bus_address;
      out_q.cpu_clock_enable <= s1_q.cpu_clock_enable;
      out_q.oam_write        <= s1_q.oam_write;
      out_q.oam_index        <= s1_q.oam_index;
      out_q.oam_data         <= s1_q.oam_data;
      out_q.dma_active       <= s1_q.dma_active;
      out_q.nmi_to_cpu       <= s1_q.nmi_to_cpu;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tdata  = {out_q.nmi_to_cpu, out_q.dma_active, out_q.oam_data, out_q.oam_index,
                          out_q.oam_write, out_q.cpu_clock_enable, out_q.bus_address,
                          out_q.ppu_peek, out_q.ppu_register, out_q.read_data};

  `CBD_ASSERT_IMP(a_clear_blocks_input, clr_busy, !s_axis_tready,
                  "Input was ready while the work RAM was being cleared.")
  `CBD_ASSERT_NXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, s1_valid_q,
                  "An accepted transaction did not reach the stage register.")
  `CBD_ASSERT_IMP(a_dma_capture_phase, s1_valid_q && s1_q.dma_capture,
                  state_q.phase == cbd_pkg::PHASE_AFTER_READ,
                  "A DMA read is pending outside the phase that follows it.")
  `CBD_ASSERT_IMP(a_cpu_or_oam, out_valid_q, !(out_q.cpu_clock_enable && out_q.oam_write),
                  "CPU enable and an OAM write were given on the same tick.")

endmodule

FILE: src/cbd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cbd_decode.sv
// Decode of one transaction: address map, controller shifters, clock phase and
// sprite DMA sequencing, all combinational. Depends on cbd_pkg.
module cbd_decode #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input  cbd_pkg::op_e                 op_i,
  input  cbd_pkg::in_t                 in_i,
  input  cbd_pkg::state_t              state_i,
  input  logic [7:0]                   dma_byte_i,
  output cbd_pkg::state_t              state_o,
  output cbd_pkg::stage_t              stage_o,
  output logic                         ram_we_o,
  output logic                         ram_re_o,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_idx_o
);

  localparam int AW = $clog2(RAM_DEPTH);
  localparam int QB = $clog2(8191 / RAM_DEPTH + 1);
  localparam int MW = 14 + QB;

  function automatic logic [AW-1:0] ram_index(input logic [12:0] a);
    logic [MW-1:0] r;
    r = MW'(a);
    for (int i = QB - 1; i >= 0; i--) begin
      if (r >= (MW'(RAM_DEPTH) << i)) begin
        r = r - (MW'(RAM_DEPTH) << i);
      end
    end
    return r[AW-1:0];
  endfunction

  logic        dma_rd;
  logic [15:0] acc_addr;
  logic        in_ram;
  logic        in_ppu;
  logic        is_pad;
  logic        is_page;
  logic        pad_k;
  logic [7:0]  next_offset;

  assign dma_rd = (op_i == cbd_pkg::OP_TICK) && (state_i.phase == cbd_pkg::PHASE_READ) &&
                  state_i.running && !state_i.waiting;
  assign acc_addr = dma_rd ? {state_i.page, state_i.offset} : in_i.address;
  assign in_ram   = acc_addr <= cbd_pkg::RAM_END;
  assign in_ppu   = (acc_addr >= cbd_pkg::PPU_BASE) && (acc_addr <= cbd_pkg::PPU_END);
  assign is_pad   = (acc_addr == cbd_pkg::PAD0_ADDR) || (acc_addr == cbd_pkg::PAD1_ADDR);
  assign is_page  = acc_addr == cbd_pkg::DMA_PAGE_ADDR;
  assign pad_k    = acc_addr[0];
  assign next_offset = state_i.offset + 8'd1;
  assign ram_idx_o   = ram_index(acc_addr[12:0]);

  always_comb begin
    state_o  = state_i;
    stage_o  = '0;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;

    if ((op_i == cbd_pkg::OP_READ) || dma_rd) begin
      stage_o.bus_address = acc_addr;
      stage_o.dma_capture = dma_rd;
      priority if (in_i.cart_hit) begin
        stage_o.target = cbd_pkg::TGT_CART;
        stage_o.rd_imm = in_i.cart_data;
      end else if (in_ram) begin
        stage_o.target      = cbd_pkg::TGT_RAM;
        stage_o.rd_from_ram = 1'b1;
        ram_re_o            = 1'b1;
      end else if (in_ppu) begin
        stage_o.target       = cbd_pkg::TGT_PPU;
        stage_o.rd_imm       = in_i.ppu_data;
        stage_o.ppu_register = acc_addr[2:0];
        stage_o.ppu_peek     = !dma_rd && in_i.read_only;
      end else if (is_pad) begin
        stage_o.target           = cbd_pkg::TGT_PAD;
        stage_o.rd_imm           = {7'd0, state_i.pad_shift[pad_k][7]};
        state_o.pad_shift[pad_k] = {state_i.pad_shift[pad_k][6:0], 1'b0};
      end
    end

    unique case (op_i)
      cbd_pkg::OP_WRITE: begin
        stage_o.bus_address = in_i.address;
        priority if (in_i.cart_hit) begin
          stage_o.target = cbd_pkg::TGT_CART;
        end else if (in_ram) begin
          stage_o.target = cbd_pkg::TGT_RAM;
          ram_we_o       = 1'b1;
        end else if (in_ppu) begin
          stage_o.target       = cbd_pkg::TGT_PPU;
          stage_o.ppu_register = in_i.address[2:0];
        end else if (is_page) begin
          stage_o.target  = cbd_pkg::TGT_DMA;
          state_o.page    = in_i.write_data;
          state_o.offset  = 8'd0;
          state_o.running = 1'b1;
        end else if (is_pad) begin
          stage_o.target           = cbd_pkg::TGT_PAD;
          state_o.pad_shift[pad_k] = pad_k ? in_i.pad_b : in_i.pad_a;
        end
      end
      cbd_pkg::OP_TICK: begin
        if ((state_i.phase == cbd_pkg::PHASE_READ) || (state_i.phase == cbd_pkg::PHASE_WRITE)) begin
          if (!state_i.running) begin
            stage_o.cpu_clock_enable = 1'b1;
          end else if (state_i.waiting) begin
            if (state_i.phase == cbd_pkg::PHASE_WRITE) begin
              state_o.waiting = 1'b0;
            end
          end else if (state_i.phase == cbd_pkg::PHASE_WRITE) begin
            stage_o.oam_write = 1'b1;
            stage_o.oam_index = state_i.offset;
            stage_o.oam_data  = dma_byte_i;
            state_o.offset    = next_offset;
            if (next_offset == 8'd0) begin
              state_o.running = 1'b0;
              state_o.waiting = 1'b1;
            end
          end
        end
        stage_o.nmi_to_cpu = in_i.nmi_pending;
        state_o.phase = (state_i.phase >= cbd_pkg::PHASE_LAST) ? 3'd0 : state_i.phase + 3'd1;
      end
      default: begin
      end
    endcase

    stage_o.dma_active = state_o.running;
  end

endmodule
